/* sv/md5_message_digest_top_macros.svh */
// Assertion macros for the MD5 digest block.
// Included by the top level; assertions drop out when NO_ASSERTIONS is defined.
`ifndef MD5_MESSAGE_DIGEST_TOP_MACROS_SVH
`define MD5_MESSAGE_DIGEST_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define MD5_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define MD5_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define MD5_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define MD5_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

/* sv/md5_pkg.sv */
// Shared constants, types and helper functions for the MD5 digest block.
// No dependencies.
package md5_pkg;

  localparam logic [31:0] IV [4] = '{32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476};

  localparam logic [31:0] K_TABLE [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee, 32'hf57c0faf, 32'h4787c62a,
    32'ha8304613, 32'hfd469501, 32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821, 32'hf61e2562, 32'hc040b340,
    32'h265e5a51, 32'he9b6c7aa, 32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed, 32'ha9e3e905, 32'hfcefa3f8,
    32'h676f02d9, 32'h8d2a4c8a, 32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70, 32'h289b7ec6, 32'heaa127fa,
    32'hd4ef3085, 32'h04881d05, 32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039, 32'h655b59c3, 32'h8f0ccc92,
    32'hffeff47d, 32'h85845dd1, 32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};

  localparam logic [4:0] ROT_TABLE [16] = '{5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14,
    5'd20, 5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21};

  localparam logic [7:0] PAD_BYTE = 8'h80;

  // Round core controls passed from the sequencer.
  typedef struct packed {
    logic       load;   // copy chaining value into a..d
    logic       step;   // run one round
    logic       fold;   // add a..d into chaining value
    logic       init;   // restore the initial vector
    logic [5:0] round;
  } core_ctl_t;

  // Message schedule index for a round.
  function automatic logic [3:0] msg_index(input logic [5:0] r);
    logic [3:0] i;
    i = r[3:0];
    unique case (r[5:4])
      2'd0: msg_index = i;
      2'd1: msg_index = 4'((i << 2) + i + 4'd1);
      2'd2: msg_index = 4'((i << 1) + i + 4'd5);
      default: msg_index = 4'((i << 3) - i);
    endcase
  endfunction

  function automatic logic [31:0] swap32(input logic [31:0] v);
    swap32 = {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

endpackage

/* sv/md5_stream_if.sv */
// Valid/ready channel carrying a generic payload word.
// Depends on nothing; payload type is set per instance.
interface md5_stream_if #(parameter type payload_t = logic) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* sv/md5_ram.sv */
// Generic simple dual-port RAM (one write port, one read port) with registered read.
// No dependencies.
module md5_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

/* sv/md5_core.sv */
// MD5 round unit: working registers, one round per cycle, chaining value.
// Depends on md5_pkg.
module md5_core (
  input  logic              clk,
  input  logic              rst,
  input  md5_pkg::core_ctl_t ctl,
  input  logic [31:0]       m_word,
  input  logic [1:0]        cv_sel,
  output logic [31:0]       cv_word
);
  logic [31:0] a, b, c, d;
  logic [31:0] cv [4];
  logic [31:0] f, sum, rot;
  logic [4:0]  s;

  // Round function and rotate.
  always_comb begin
    unique case (ctl.round[5:4])
      2'd0: f = (b & c) | (~b & d);
      2'd1: f = (b & d) | (c & ~d);
      2'd2: f = b ^ c ^ d;
      default: f = c ^ (b | ~d);
    endcase
    sum = a + f + md5_pkg::K_TABLE[ctl.round] + m_word;
    s = md5_pkg::ROT_TABLE[{ctl.round[5:4], ctl.round[1:0]}];
    rot = (sum << s) | (sum >> (6'd32 - {1'b0, s}));
  end

  // Working registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      a <= '0; b <= '0; c <= '0; d <= '0;
    end else if (ctl.load) begin
      a <= cv[0]; b <= cv[1]; c <= cv[2]; d <= cv[3];
    end else if (ctl.step) begin
      a <= d; d <= c; c <= b; b <= b + rot;
    end
  end

  // Chaining value.
  always_ff @(posedge clk) begin
    if (rst || ctl.init) begin
      for (int i = 0; i < 4; i++) cv[i] <= md5_pkg::IV[i];
    end else if (ctl.fold) begin
      cv[0] <= cv[0] + a; cv[1] <= cv[1] + b;
      cv[2] <= cv[2] + c; cv[3] <= cv[3] + d;
    end
  end

  assign cv_word = md5_pkg::swap32(cv[cv_sel]);
endmodule

/* sv/md5_message_digest_top.sv */
// Top level of the MD5 digest block: byte packing, padding sequencer, output.
// Depends on md5_pkg, md5_stream_if, md5_ram, md5_core and the macros header.
//
//  channel  dir  payload                                  handshake
//  in       sink data_byte[7:0] byte_valid last_byte      valid/ready
//  out      src  digest_word[31:0] word_index digest_last valid/ready
//
// A filling byte adds a compression (load, 64 rounds, fold) on the round
// unit. A final byte adds padding at one byte per cycle plus one or two
// compressions, then four output words. Reset is synchronous; the block
// buffer is not cleared.
// Output stalls hold the block; input is not taken until the digest drains.
`include "md5_message_digest_top_macros.svh"
module md5_message_digest_top (
  input logic clk,
  input logic rst,
  md5_stream_if.sink   in_ch,
  md5_stream_if.source out_ch
);
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001, S_LOAD = 6'b000010, S_ROUND = 6'b000100,
    S_FOLD = 6'b001000, S_PAD  = 6'b010000, S_OUT  = 6'b100000
  } state_t;

  state_t      state;
  logic [63:0] bit_count, len_hold;
  logic [5:0]  byte_pos, round;
  logic        padding;
  logic        ending;
  logic        wrap_pad;
  logic        len_block;
  logic        len_done;
  logic [1:0]  out_idx;
  logic [31:0] word_reg;
  logic [31:0] rdata;
  logic        we;
  logic [3:0]  waddr, raddr;
  logic [31:0] wdata;
  logic [7:0]  wbyte;
  logic        take;
  md5_pkg::core_ctl_t ctl;
  logic [31:0] cv_word;

  assign in_ch.ready = (state == S_IDLE);
  assign take = in_ch.valid && in_ch.ready;

  // The current padding block carries the length unless the 0x80 byte
  // landed in its last eight lanes.
  assign len_block = !(wrap_pad || (padding && byte_pos >= 6'd56));

  // Byte into the word being assembled; a full word goes to the RAM.
  always_comb begin
    wbyte = in_ch.data.data_byte;
    if (state == S_PAD) begin
      if (padding) wbyte = md5_pkg::PAD_BYTE;
      else if (len_block && byte_pos >= 6'd56) wbyte = len_hold[{byte_pos[2:0], 3'b000} +: 8];
      else wbyte = '0;
    end
    wdata = {wbyte, word_reg[31:8]};
    waddr = byte_pos[5:2];
    we = ((take && in_ch.data.byte_valid) || state == S_PAD) && byte_pos[1:0] == 2'd3;
  end

  // Prefetch next round's schedule word (registered read).
  always_comb begin
    if (state == S_LOAD) raddr = md5_pkg::msg_index(6'd0);
    else raddr = md5_pkg::msg_index(6'(round + 6'd1));
  end

  md5_ram #(.WIDTH(32), .DEPTH(16)) u_buf (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata));

  always_comb begin
    ctl.load  = (state == S_LOAD);
    ctl.step  = (state == S_ROUND);
    ctl.fold  = (state == S_FOLD);
    ctl.init  = (state == S_OUT) && out_ch.ready && out_idx == 2'd3;
    ctl.round = round;
  end

  md5_core u_core (.clk(clk), .rst(rst), .ctl(ctl), .m_word(rdata),
    .cv_sel(out_idx), .cv_word(cv_word));

  // Length bookkeeping: wrap_pad marks a block whose tail holds the 0x80 byte,
  // and len_done is set once the block carrying the length has been written.
  always_ff @(posedge clk) begin
    if (rst) begin
      wrap_pad <= 1'b0;
      len_done <= 1'b0;
    end else begin
      if (state == S_PAD && padding && byte_pos >= 6'd56) wrap_pad <= 1'b1;
      else if (state == S_FOLD) wrap_pad <= 1'b0;
      if (state == S_PAD && byte_pos == 6'd63 && len_block) len_done <= 1'b1;
      else if (state == S_OUT) len_done <= 1'b0;
    end
  end

  // Sequencer. padding is set while the 0x80 byte is still owed.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; bit_count <= '0; byte_pos <= '0; round <= '0;
      padding <= 1'b0; out_idx <= '0; ending <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (take) begin
          if (in_ch.data.byte_valid) begin
            word_reg <= wdata;
            byte_pos <= byte_pos + 6'd1;
            bit_count <= bit_count + 64'd8;
          end
          if (in_ch.data.last_byte) begin
            ending <= 1'b1;
            len_hold <= in_ch.data.byte_valid ? bit_count + 64'd8 : bit_count;
            padding <= 1'b1;
          end
          if (in_ch.data.byte_valid && byte_pos == 6'd63) state <= S_LOAD;
          else if (in_ch.data.last_byte) state <= S_PAD;
        end
        S_PAD: begin
          word_reg <= wdata;
          padding <= 1'b0;
          byte_pos <= byte_pos + 6'd1;
          if (byte_pos == 6'd63) state <= S_LOAD;
        end
        S_LOAD: begin round <= '0; state <= S_ROUND; end
        S_ROUND: begin
          round <= round + 6'd1;
          if (round == 6'd63) state <= S_FOLD;
        end
        S_FOLD: begin
          if (!ending) state <= S_IDLE;
          else if (padding || !len_done) state <= S_PAD;
          else begin state <= S_OUT; out_idx <= '0; end
        end
        S_OUT: if (out_ch.ready) begin
          out_idx <= out_idx + 2'd1;
          if (out_idx == 2'd3) begin
            state <= S_IDLE; ending <= 1'b0; bit_count <= '0; byte_pos <= '0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid = (state == S_OUT);
  assign out_ch.data.digest_word = cv_word;
  assign out_ch.data.word_index = out_idx;
  assign out_ch.data.digest_last = (out_idx == 2'd3);

  `MD5_ASSERT_IMPL(a_ready_idle, clk, rst, in_ch.ready, !out_ch.valid, "ready during output")
  `MD5_ASSERT_NEXT(a_round_wrap, clk, rst, state == S_ROUND && round == 6'd63, state == S_FOLD, "round count")
  `MD5_ASSERT_IMPL(a_pad_end, clk, rst, state == S_OUT, ending, "output without message end")
endmodule
